@@ rtl/slid_pkg.sv @@
// Shared types for the sorted list: operation and status codes, cell control and flags.
package slid_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    ORD_ASCENDING  = 1'b0,
    ORD_DESCENDING = 1'b1
  } order_e;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic   mark_load;  // set all marks: scan token at cell 0
    logic   mark_step;  // move the scan token one cell to the right
    logic   shift_ins;  // open a gap at the token and drop the key in
    logic   shift_del;  // close the gap at the token
    order_e order;
  } cell_ctrl_t;

  // What a cell reports while it holds the scan token.
  typedef struct packed {
    logic tok;   // token sits here
    logic ins;   // key belongs in this position
    logic del;   // this entry equals the key
    logic miss;  // cell is empty, end of the list
  } cell_flags_t;

endpackage

@@ rtl/sorted_list_insert_delete.sv @@
// Sorted list top level: command port, scan sequencer and the row of cells.
//
// Usage: present operation_i and value_i with start high; the command is
// taken at a clock edge where start is high and busy is low. One result per
// command comes back on status_o and count_o, valid for exactly one cycle
// while done_o is high; the receiver cannot hold it off.
// Entries live in a row of CAPACITY cells kept in order. A scan token walks
// the row one cell per cycle from the front; an insert opens a gap at the
// first entry that sorts after the new value, a remove closes the gap at the
// first equal entry. Each shift moves the whole row at once.
// An insert or remove finishes when the token stops at its cell; the worst
// case is set by the token walking the cell row. An insert into a full list
// answers in the next cycle, without a scan. busy is low again in the cycle
// done_o is high, so the next command may be given then.
// cfg_we_i/cfg_wdata_i write order_mode (0 ascending, 1 descending); write
// it only while idle.
// Reset empties the list, clears count_o and selects ascending order.
module sorted_list_insert_delete #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int CntW        = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [CntW-1:0]               count_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  slid_pkg::op_e                 op_q;
  logic signed [VALUE_WIDTH-1:0] key_q;
  slid_pkg::order_e              order_q;
  logic [CntW-1:0]               count_q, count_d;
  logic                          done_q, done_d;
  slid_pkg::status_e             status_q, status_d;
  slid_pkg::cell_ctrl_t          ctrl;
  logic                          accept;

  logic [CAPACITY-1:0]           valid_w, mark_w, tok_w, ins_w, del_w, miss_w;
  logic signed [VALUE_WIDTH-1:0] value_w [CAPACITY];
  slid_pkg::cell_flags_t         flags_w [CAPACITY];

  assign accept = start & ~busy;
  assign busy   = (state_q != S_IDLE);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                          lv, lm, rv;
      logic signed [VALUE_WIDTH-1:0] lval, rval;
      if (gi == 0) begin : g_first
        assign lv   = 1'b0;
        assign lm   = 1'b0;
        assign lval = '0;
      end else begin : g_mid
        assign lv   = valid_w[gi-1];
        assign lm   = mark_w[gi-1];
        assign lval = value_w[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign rv   = 1'b0;
        assign rval = '0;
      end else begin : g_inner
        assign rv   = valid_w[gi+1];
        assign rval = value_w[gi+1];
      end

      slid_cell #(
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .key_i        (key_q),
        .left_valid_i (lv),
        .left_value_i (lval),
        .left_mark_i  (lm),
        .right_valid_i(rv),
        .right_value_i(rval),
        .valid_o      (valid_w[gi]),
        .value_o      (value_w[gi]),
        .mark_o       (mark_w[gi]),
        .flags_o      (flags_w[gi])
      );

      assign tok_w[gi]  = flags_w[gi].tok;
      assign ins_w[gi]  = flags_w[gi].ins;
      assign del_w[gi]  = flags_w[gi].del;
      assign miss_w[gi] = flags_w[gi].miss;
    end
  endgenerate

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    done_d         = 1'b0;
    status_d       = status_q;
    ctrl.mark_load = 1'b0;
    ctrl.mark_step = 1'b0;
    ctrl.shift_ins = 1'b0;
    ctrl.shift_del = 1'b0;
    ctrl.order     = order_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((slid_pkg::op_e'(operation_i) == slid_pkg::OP_INSERT) &&
              (count_q == CntW'(CAPACITY))) begin
            done_d   = 1'b1;
            status_d = slid_pkg::ST_FULL;
          end else begin
            ctrl.mark_load = 1'b1;
            state_d        = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (op_q == slid_pkg::OP_INSERT) begin
          if (|ins_w) begin
            ctrl.shift_ins = 1'b1;
            count_d        = count_q + CntW'(1);
            done_d         = 1'b1;
            status_d       = slid_pkg::ST_DONE;
            state_d        = S_IDLE;
          end else if (|tok_w) begin
            ctrl.mark_step = 1'b1;
          end else begin
            // token ran off a full row; not reached given the full check
            done_d   = 1'b1;
            status_d = slid_pkg::ST_FULL;
            state_d  = S_IDLE;
          end
        end else begin
          if (|del_w) begin
            ctrl.shift_del = 1'b1;
            count_d        = count_q - CntW'(1);
            done_d         = 1'b1;
            status_d       = slid_pkg::ST_DONE;
            state_d        = S_IDLE;
          end else if ((|miss_w) || !(|tok_w)) begin
            done_d   = 1'b1;
            status_d = slid_pkg::ST_NOT_FOUND;
            state_d  = S_IDLE;
          end else begin
            ctrl.mark_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      order_q <= slid_pkg::ORD_ASCENDING;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        order_q <= slid_pkg::order_e'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (accept) begin
      op_q  <= slid_pkg::op_e'(operation_i);
      key_q <= value_i;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign count_o  = count_q;

endmodule

@@ rtl/slid_cell.sv @@
// One cell of the list: an entry with its valid bit and the scan-token mark.
module slid_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slid_pkg::cell_ctrl_t          ctrl_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  input  logic                          left_valid_i,
  input  logic signed [VALUE_WIDTH-1:0] left_value_i,
  input  logic                          left_mark_i,
  input  logic                          right_valid_i,
  input  logic signed [VALUE_WIDTH-1:0] right_value_i,
  output logic                          valid_o,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          mark_o,
  output slid_pkg::cell_flags_t         flags_o
);

  logic                          valid_q, valid_d;
  logic                          mark_q, mark_d;
  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  logic                          tok;
  logic                          after_key;

  // marks form a thermometer: set from the token position rightward
  assign tok = mark_q & ~left_mark_i;

  // entry sorts strictly after the key under the current order
  assign after_key = (ctrl_i.order == slid_pkg::ORD_DESCENDING) ? (value_q < key_i)
                                                                : (value_q > key_i);

  always_comb begin
    flags_o.tok  = tok;
    flags_o.ins  = tok & (~valid_q | after_key);
    flags_o.del  = tok & valid_q & (value_q == key_i);
    flags_o.miss = tok & ~valid_q;
  end

  always_comb begin
    mark_d  = mark_q;
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.mark_load) begin
      mark_d = 1'b1;
    end else if (ctrl_i.mark_step) begin
      mark_d = left_mark_i;
    end
    if (ctrl_i.shift_ins && mark_q) begin
      if (tok) begin
        valid_d = 1'b1;
        value_d = key_i;
      end else begin
        valid_d = left_valid_i;
        value_d = left_value_i;
      end
    end else if (ctrl_i.shift_del && mark_q) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mark_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      mark_q  <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign mark_o  = mark_q;

endmodule

@@ rtl/slid_checker.sv @@
// Port-level checks for the sorted list, bound to the top level.
module slid_checker #(
  parameter int CAPACITY = 64,
  parameter int CntW     = $clog2(CAPACITY + 1)
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input logic [1:0]      status_o,
  input logic [CntW-1:0] count_o
);

  // a taken command either keeps the block busy or answers at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("command taken without busy or result");

  // count moves only together with a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(count_o))
    else $error("count changed without a result");

  // a failed command leaves the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != slid_pkg::ST_DONE)) |-> $stable(count_o))
    else $error("count changed on a failed command");

  // a successful command changes the count by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == slid_pkg::ST_DONE)) |->
      ((count_o == CntW'($past(count_o) + CntW'(1))) ||
       (count_o == CntW'($past(count_o) - CntW'(1)))))
    else $error("count step on success is not one");

  // full is only reported with the list at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == slid_pkg::ST_FULL)) |-> (count_o == CntW'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

bind sorted_list_insert_delete slid_checker #(
  .CAPACITY(CAPACITY),
  .CntW    (CntW)
) u_slid_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .status_o(status_o),
  .count_o (count_o)
);
